// ===== design/tdpt_pkg.sv =====
// ----------------------------------------------------------------------------
// tdpt_pkg
// Shared types for the trial division prime test: status that the remainder
// unit reports to the sequencer.
// ----------------------------------------------------------------------------
package tdpt_pkg;

  typedef struct packed {
    logic busy;  // remainder unit is stepping
    logic done;  // remainder valid this cycle
  } rem_stat_t;

endpackage

// ===== design/trial_division_prime_test.sv =====
// ----------------------------------------------------------------------------
// trial_division_prime_test
// Primality test by trial division, one candidate word at a time.
// ----------------------------------------------------------------------------
// Each candidate is tested against divisors 2, 3, 4, ... while the divisor
// squared does not exceed it, stopping at the first divisor that leaves no
// remainder; 0 and 1 are reported not prime. One shared restoring remainder
// unit does all the division, one bit per cycle. A prime n is tried against
// every divisor up to floor(sqrt(n)); 0 and 1 never reach the remainder unit,
// and neither do 2 and 3, since 4 already exceeds them. A composite stops at
// its smallest divisor. The divisor square is kept as a running sum, so no
// multiplier is used. The input is not ready while a candidate is being
// tested; a finished result sits in an output register, and the next
// candidate is taken while it waits.
module trial_division_prime_test #(
  parameter int VALUE_BITS = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [VALUE_BITS-1:0] candidate_i,
  input  logic                  last_in_range_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [VALUE_BITS-1:0] tested_value_o,
  output logic                  is_prime_o,
  output logic                  last_result_o
);
  import tdpt_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_CHECK = 4'b0010,
    ST_DIV   = 4'b0100,
    ST_DONE  = 4'b1000
  } tdpt_state_e;

  tdpt_state_e state_q, state_d;

  logic [VALUE_BITS-1:0] n_q, n_d;
  logic                  last_q, last_d;
  logic [VALUE_BITS-1:0] div_q, div_d;
  logic [VALUE_BITS:0]   sq_q, sq_d;
  logic                  prime_q, prime_d;

  logic                  out_valid_q, out_valid_d;
  logic [VALUE_BITS-1:0] out_val_q;
  logic                  out_prime_q;
  logic                  out_last_q;
  logic                  out_load;

  logic                  rem_start;
  rem_stat_t             rem_stat;
  logic                  rem_zero;

  tdpt_rem_unit #(
    .Width(VALUE_BITS)
  ) u_rem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (rem_start),
    .dividend_i(n_q),
    .divisor_i (div_q),
    .stat_o    (rem_stat),
    .rem_zero_o(rem_zero)
  );

  assign in_ready_o = (state_q == ST_IDLE);
  assign out_load   = (state_q == ST_DONE) && (!out_valid_q || out_ready_i);

  always_comb begin
    state_d   = state_q;
    n_d       = n_q;
    last_d    = last_q;
    div_d     = div_q;
    sq_d      = sq_q;
    prime_d   = prime_q;
    rem_start = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          n_d    = candidate_i;
          last_d = last_in_range_i;
          div_d  = VALUE_BITS'(2);
          sq_d   = (VALUE_BITS + 1)'(4);
          if (candidate_i < VALUE_BITS'(2)) begin
            prime_d = 1'b0;
            state_d = ST_DONE;
          end else begin
            state_d = ST_CHECK;
          end
        end
      end
      ST_CHECK: begin
        // Past the square root with no divisor found: prime.
        if (sq_q > {1'b0, n_q}) begin
          prime_d = 1'b1;
          state_d = ST_DONE;
        end else begin
          rem_start = 1'b1;
          state_d   = ST_DIV;
        end
      end
      ST_DIV: begin
        if (rem_stat.done) begin
          if (rem_zero) begin
            prime_d = 1'b0;
            state_d = ST_DONE;
          end else begin
            // (d+1)^2 = d^2 + 2d + 1
            sq_d    = sq_q + {div_q, 1'b1};
            div_d   = div_q + VALUE_BITS'(1);
            state_d = ST_CHECK;
          end
        end
      end
      ST_DONE: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q     <= n_d;
    last_q  <= last_d;
    div_q   <= div_d;
    sq_q    <= sq_d;
    prime_q <= prime_d;
    if (out_load) begin
      out_val_q   <= n_q;
      out_prime_q <= prime_q;
      out_last_q  <= last_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign tested_value_o = out_val_q;
  assign is_prime_o     = out_prime_q;
  assign last_result_o  = out_last_q;

  // Start the remainder unit only when it is free.
  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rem_start |-> !rem_stat.busy)
    else $error("remainder unit started while busy");

  // An even division is only ever found at or below the square root.
  a_div_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV && rem_stat.done) |-> (sq_q <= {1'b0, n_q}))
    else $error("divisor beyond square root");

  // Never report 0 or 1 as prime.
  a_small_not_prime: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> !(prime_q && (n_q < VALUE_BITS'(2))))
    else $error("value below two flagged prime");

  // A waiting result word is never overwritten.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ready_i) |-> !out_load)
    else $error("pending result overwritten");

endmodule

// ===== design/tdpt_rem_unit.sv =====
// ----------------------------------------------------------------------------
// tdpt_rem_unit
// Iterative restoring remainder unit: one dividend bit per cycle; each
// finished remainder is flagged by a done pulse.
// ----------------------------------------------------------------------------
module tdpt_rem_unit #(
  parameter int Width = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic [Width-1:0]    dividend_i,
  input  logic [Width-1:0]    divisor_i,
  output tdpt_pkg::rem_stat_t stat_o,
  output logic                rem_zero_o
);
  import tdpt_pkg::*;

  localparam int CntW = $clog2(Width + 1);

  logic [Width-1:0] dvd_q, dvd_d;
  logic [Width-1:0] dvs_q, dvs_d;
  logic [Width-1:0] rem_q, rem_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [Width:0]   trial;
  logic [Width:0]   diff;

  // Bring down the next dividend bit and subtract the divisor if it fits.
  assign trial = {rem_q, dvd_q[Width-1]};
  assign diff  = trial - {1'b0, dvs_q};

  always_comb begin
    dvd_d  = dvd_q;
    dvs_d  = dvs_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i && !busy_q) begin
      dvd_d  = dividend_i;
      dvs_d  = divisor_i;
      rem_d  = '0;
      cnt_d  = CntW'(Width);
      busy_d = 1'b1;
    end else if (busy_q) begin
      dvd_d = {dvd_q[Width-2:0], 1'b0};
      if (trial >= {1'b0, dvs_q}) begin
        rem_d = diff[Width-1:0];
      end else begin
        rem_d = trial[Width-1:0];
      end
      cnt_d = cnt_q - CntW'(1);
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    dvs_q <= dvs_d;
    rem_q <= rem_d;
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign rem_zero_o  = (rem_q == '0);

endmodule
